// ===== src/power_regulated_cosine_drive_unit_defines.svh =====
// assertion macros for the cosine drive unit
`ifndef POWER_REGULATED_COSINE_DRIVE_UNIT_DEFINES_SVH
`define POWER_REGULATED_COSINE_DRIVE_UNIT_DEFINES_SVH

// property checked on every rising edge outside reset
`define PRCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define PRCD_ASSERT_NEVER(lbl, cond, msg) \
	`PRCD_ASSERT(lbl, !(cond), msg)

`endif

// ===== src/prcd_pkg.sv =====
`default_nettype none

package prcd_pkg;

	localparam int DEF_COS_TABLE_DEPTH = 1024;
	localparam int DEF_MAX_SAMPLES = 65535;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_POWER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_AMPLITUDE = 3'd4;

	localparam int SUM_W = 40;
	localparam int DIV_STEPS = 40;
	localparam int FACTOR_HI = 72090;
	localparam int FACTOR_LO = 58982;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	typedef struct packed {
		logic [31:0] time_stamp;
		logic [23:0] power_sample;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] drive_value;
		logic signed [31:0] amplitude_now;
		logic [23:0]        average_power;
		logic               period_done;
	} out_beat_t;

endpackage

`default_nettype wire

// ===== src/power_regulated_cosine_drive_unit.sv =====
// flow: a beat passes the phase, index, ROM, drive and output states; once the
//   period has run out, two 40-step shared divider passes and the amplitude
//   update run between index and ROM; a new beat is taken only when idle
// reset: arst_n clears amplitude, sum, count, last update time and average,
//   and loads register defaults (target power 1, all others zero)
`default_nettype none

`include "power_regulated_cosine_drive_unit_defines.svh"

module power_regulated_cosine_drive_unit #(
	parameter int COS_TABLE_DEPTH = prcd_pkg::DEF_COS_TABLE_DEPTH,
	parameter int MAX_SAMPLES = prcd_pkg::DEF_MAX_SAMPLES
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire prcd_pkg::in_beat_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output prcd_pkg::out_beat_t                 out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [prcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);

	localparam int KW = $clog2(COS_TABLE_DEPTH);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SW = prcd_pkg::SUM_W;
	localparam int PMW = 32 + KW + 1;
	localparam int DCW = $clog2(prcd_pkg::DIV_STEPS);
	localparam longint Q30_ONE = 64'sd1 <<< 30;
	localparam logic signed [59:0] F30_ONE = 60'sd1 <<< 30;
	localparam logic signed [59:0] F30_HI = 60'(prcd_pkg::FACTOR_HI) <<< 14;
	localparam logic signed [59:0] F30_LO = 60'(prcd_pkg::FACTOR_LO) <<< 14;

	typedef logic signed [15:0] cos_rom_t [COS_TABLE_DEPTH];

	function automatic longint mul30(input longint a, input longint b);
		return (a * b) / Q30_ONE;
	endfunction

	function automatic logic signed [15:0] cos_entry(input longint k);
		longint u, quad, x, x2, c, s, v, mag;
		logic neg;
		u = (k <<< 32) / COS_TABLE_DEPTH;
		quad = u >>> 30;
		x = ((u & 64'sh3FFFFFFF) * prcd_pkg::HALF_PI_Q30) >>> 30;
		x2 = mul30(x, x);
		c = Q30_ONE - x2 / 90;
		c = Q30_ONE - mul30(x2, c) / 56;
		c = Q30_ONE - mul30(x2, c) / 30;
		c = Q30_ONE - mul30(x2, c) / 12;
		c = Q30_ONE - mul30(x2, c) / 2;
		s = Q30_ONE - x2 / 110;
		s = Q30_ONE - mul30(x2, s) / 72;
		s = Q30_ONE - mul30(x2, s) / 42;
		s = Q30_ONE - mul30(x2, s) / 20;
		s = Q30_ONE - mul30(x2, s) / 6;
		s = mul30(x, s);
		if (quad == 0) v = c;
		else if (quad == 1) v = -s;
		else if (quad == 2) v = -c;
		else v = s;
		neg = (v < 0);
		mag = neg ? -v : v;
		mag = (mag + 64'sd16384) >>> 15;
		v = neg ? -mag : mag;
		if (v > 32767) v = 32767;
		if (v < -32767) v = -32767;
		return 16'(v);
	endfunction

	function automatic cos_rom_t gen_rom();
		cos_rom_t r;
		for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
			r[i] = cos_entry(longint'(i));
		end
		return r;
	endfunction

	localparam cos_rom_t COS_ROM = gen_rom();

	typedef enum logic [3:0] {
		S_IDLE,
		S_PHASE,
		S_INDEX,
		S_DIVA,
		S_DIVR,
		S_MULG,
		S_FACT,
		S_AMP,
		S_RND,
		S_ROM,
		S_DRV,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] phase_step_q;
	logic [31:0] period_length_q;
	logic [23:0] target_power_q;
	logic [15:0] damping_gain_q;

	// regulation state
	logic signed [31:0] amp_q;
	logic [SW-1:0]      sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [31:0]        last_t_q;
	logic [23:0]        last_avg_q;
	logic               done_q;
	logic               upd_q;
	logic               out_valid_q;
	logic [DCW-1:0]     div_cnt_q;

	// datapath
	logic [31:0]        t_q;
	logic [31:0]        phase_q;
	logic [KW-1:0]      k_q;
	logic signed [15:0] rom_q;
	logic [SW-1:0]      dq_q;
	logic [23:0]        rem_q;
	logic [23:0]        dvs_q;
	logic [23:0]        avg_q;
	logic [SW-1:0]      r_q;
	logic signed [58:0] prod_q;
	logic signed [17:0] factor_q;
	logic signed [49:0] na_q;
	logic signed [47:0] dp_q;
	prcd_pkg::out_beat_t out_q;

	logic               accept;
	logic [SW:0]        sum_add;
	logic [SW-1:0]      sum_nxt;
	logic [31:0]        elapsed;
	logic [PMW-1:0]     idx_prod;
	logic [24:0]        rem_sh;
	logic [24:0]        rem_diff;
	logic               div_ge;
	logic [SW-1:0]      dq_nxt;
	logic [23:0]        rem_nxt;
	logic               div_last;
	logic [23:0]        avg_sat;
	logic [23:0]        tgt;
	logic signed [41:0] r_off;
	logic signed [59:0] f30;
	logic               na_neg;
	logic [49:0]        na_mag;
	logic [33:0]        na_rnd;
	logic signed [31:0] amp_nxt;
	logic               dp_neg;
	logic [47:0]        dp_mag;
	logic [32:0]        dp_rnd;
	logic [31:0]        drive_nxt;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign sum_add = {1'b0, sum_q} + {{(SW + 1 - 24){1'b0}}, in_data.power_sample};
	assign sum_nxt = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
	assign elapsed = t_q - last_t_q;
	assign idx_prod = PMW'(phase_q) * PMW'(COS_TABLE_DEPTH);

	// shared restoring divider step
	assign rem_sh = {rem_q, dq_q[SW-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign div_ge = (rem_sh >= {1'b0, dvs_q});
	assign rem_nxt = div_ge ? rem_diff[23:0] : rem_sh[23:0];
	assign dq_nxt = {dq_q[SW-2:0], div_ge};
	assign div_last = (div_cnt_q == DCW'(prcd_pkg::DIV_STEPS - 1));
	assign avg_sat = (dq_nxt[SW-1:24] != '0) ? 24'hFFFFFF : dq_nxt[23:0];
	assign tgt = (target_power_q == '0) ? 24'd1 : target_power_q;

	assign r_off = $signed({2'b00, r_q}) - 42'sd65536;
	assign f30 = F30_ONE - {prod_q[58], prod_q};

	assign na_neg = na_q[49];
	assign na_mag = na_neg ? 50'(-na_q) : 50'(na_q);
	assign na_rnd = 34'((na_mag + 50'd32768) >> 16);

	always_comb begin
		if (!na_neg && na_rnd > 34'h07FFFFFFF) begin
			amp_nxt = 32'sh7FFFFFFF;
		end else if (na_neg && na_rnd > 34'h080000000) begin
			amp_nxt = 32'sh80000000;
		end else if (na_neg) begin
			amp_nxt = 32'(-na_rnd);
		end else begin
			amp_nxt = na_rnd[31:0];
		end
	end

	assign dp_neg = dp_q[47];
	assign dp_mag = dp_neg ? 48'(-dp_q) : 48'(dp_q);
	assign dp_rnd = 33'((dp_mag + 48'd16384) >> 15);
	assign drive_nxt = dp_neg ? 32'(-dp_rnd) : dp_rnd[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_step_q <= '0;
			period_length_q <= '0;
			target_power_q <= 24'd1;
			damping_gain_q <= '0;
			amp_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			last_t_q <= '0;
			last_avg_q <= '0;
			done_q <= 1'b0;
			upd_q <= 1'b0;
			out_valid_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					prcd_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data;
					prcd_pkg::REG_PERIOD_LENGTH: period_length_q <= cfg_data;
					prcd_pkg::REG_TARGET_POWER: target_power_q <= cfg_data[23:0];
					prcd_pkg::REG_DAMPING_GAIN: damping_gain_q <= cfg_data[15:0];
					prcd_pkg::REG_INITIAL_AMPLITUDE: amp_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sum_q <= sum_nxt;
						if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
							cnt_q <= cnt_q + 1'b1;
						end
						done_q <= 1'b0;
						state_q <= S_PHASE;
					end
				end
				S_PHASE: begin
					upd_q <= (elapsed > period_length_q);
					state_q <= S_INDEX;
				end
				S_INDEX: begin
					div_cnt_q <= '0;
					state_q <= upd_q ? S_DIVA : S_ROM;
				end
				S_DIVA: begin
					div_cnt_q <= div_last ? '0 : div_cnt_q + 1'b1;
					if (div_last) begin
						state_q <= S_DIVR;
					end
				end
				S_DIVR: begin
					div_cnt_q <= div_last ? '0 : div_cnt_q + 1'b1;
					if (div_last) begin
						state_q <= S_MULG;
					end
				end
				S_MULG: state_q <= S_FACT;
				S_FACT: state_q <= S_AMP;
				S_AMP: state_q <= S_RND;
				S_RND: begin
					amp_q <= amp_nxt;
					last_avg_q <= avg_q;
					last_t_q <= t_q;
					sum_q <= '0;
					cnt_q <= '0;
					done_q <= 1'b1;
					state_q <= S_ROM;
				end
				S_ROM: state_q <= S_DRV;
				S_DRV: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= COS_ROM[k_q];
		if (accept) begin
			t_q <= in_data.time_stamp;
		end
		unique case (state_q)
			S_PHASE: phase_q <= phase_step_q * t_q;
			S_INDEX: begin
				k_q <= idx_prod[32 +: KW];
				dq_q <= sum_q;
				rem_q <= '0;
				dvs_q <= {{(24 - CNT_W){1'b0}}, cnt_q};
			end
			S_DIVA: begin
				if (div_last) begin
					avg_q <= avg_sat;
					dq_q <= {{(SW - 40){1'b0}}, avg_sat, 16'd0};
					rem_q <= '0;
					dvs_q <= tgt;
				end else begin
					dq_q <= dq_nxt;
					rem_q <= rem_nxt;
				end
			end
			S_DIVR: begin
				dq_q <= dq_nxt;
				rem_q <= rem_nxt;
				if (div_last) begin
					r_q <= dq_nxt;
				end
			end
			S_MULG: prod_q <= $signed({1'b0, damping_gain_q}) * r_off;
			S_FACT: begin
				priority if (f30 >= F30_HI) begin
					factor_q <= 18'(prcd_pkg::FACTOR_HI);
				end else if (f30 <= F30_LO) begin
					factor_q <= 18'(prcd_pkg::FACTOR_LO);
				end else begin
					factor_q <= f30[31:14];
				end
			end
			S_AMP: na_q <= amp_q * factor_q;
			S_DRV: dp_q <= amp_q * rom_q;
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.drive_value <= drive_nxt;
					out_q.amplitude_now <= amp_q;
					out_q.average_power <= last_avg_q;
					out_q.period_done <= done_q;
				end
			end
			default: ;
		endcase
	end

	`PRCD_ASSERT(a_accept_starts, accept |=> (state_q == S_PHASE), "beat did not start work")
	`PRCD_ASSERT(a_out_from_seq, $rose(out_valid) |-> $past(state_q == S_OUT),
		"result beat raised outside output state")
	`PRCD_ASSERT_NEVER(a_cnt_range, cnt_q > CNT_W'(MAX_SAMPLES), "sample count above limit")
	`PRCD_ASSERT(a_update_clears, (state_q == S_RND) |=> (cnt_q == '0 && sum_q == '0 && done_q),
		"period update did not clear accumulator")

endmodule

`default_nettype wire

// ===== dv/power_regulated_cosine_drive_unit_tb.sv =====
`default_nettype none

module power_regulated_cosine_drive_unit_tb;

	localparam int TABLE_DEPTH = prcd_pkg::DEF_COS_TABLE_DEPTH;
	localparam int SAMPLE_CAP = prcd_pkg::DEF_MAX_SAMPLES;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint POWER_SUM_CAP = (64'sd1 <<< prcd_pkg::SUM_W) - 1;
	localparam longint MEAN_CAP = 64'sd16777215;
	localparam logic [prcd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [prcd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	prcd_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	prcd_pkg::out_beat_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [prcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	bit steady = 1'b0;
	int mismatches = 0;
	prcd_pkg::out_beat_t pending_drive[$];

	// register copies
	logic [31:0] freq_word = '0;
	logic [31:0] window_len = '0;
	logic [23:0] power_goal = 24'd1;
	logic [15:0] damp_q14 = '0;
	// regulation state
	logic signed [31:0] level = '0;
	longint acc_power = 0;
	int acc_count = 0;
	logic [31:0] mark_time = '0;
	logic [23:0] mean_power = '0;

	power_regulated_cosine_drive_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(negedge clk) out_ready <= steady || ($urandom_range(99) >= 8);

	function automatic longint round_half_away(longint v, int sh);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint mul_q30(longint a, longint b);
		return (a * b) / ONE_Q30;
	endfunction

	function automatic int cosine_q15(int k);
		logic [63:0] pos;
		logic [31:0] u;
		longint x, x2, c, s, v;
		pos = {32'(k), 32'd0} / TABLE_DEPTH;
		u = pos[31:0];
		x = longint'(({34'd0, u[29:0]} * 64'(prcd_pkg::HALF_PI_Q30)) >> 30);
		x2 = mul_q30(x, x);
		c = ONE_Q30 - x2 / 90;
		c = ONE_Q30 - mul_q30(x2, c) / 56;
		c = ONE_Q30 - mul_q30(x2, c) / 30;
		c = ONE_Q30 - mul_q30(x2, c) / 12;
		c = ONE_Q30 - mul_q30(x2, c) / 2;
		s = ONE_Q30 - x2 / 110;
		s = ONE_Q30 - mul_q30(x2, s) / 72;
		s = ONE_Q30 - mul_q30(x2, s) / 42;
		s = ONE_Q30 - mul_q30(x2, s) / 20;
		s = ONE_Q30 - mul_q30(x2, s) / 6;
		s = mul_q30(x, s);
		case (u[31:30])
			2'd0: v = c;
			2'd1: v = -s;
			2'd2: v = -c;
			default: v = s;
		endcase
		v = round_half_away(v, 15);
		if (v > 32767) v = 32767;
		if (v < -32767) v = -32767;
		return int'(v);
	endfunction

	function automatic prcd_pkg::out_beat_t predict_drive(prcd_pkg::in_beat_t b);
		prcd_pkg::out_beat_t r;
		logic [31:0] elapsed;
		logic [31:0] phase;
		logic [63:0] slot;
		longint mean, ratio, f30, factor, scaled;
		r = '0;
		acc_power = acc_power + longint'(b.power_sample);
		if (acc_power > POWER_SUM_CAP) acc_power = POWER_SUM_CAP;
		if (acc_count < SAMPLE_CAP) acc_count++;
		elapsed = b.time_stamp - mark_time;
		if (elapsed > window_len) begin
			mean = acc_power / ((acc_count == 0) ? 1 : acc_count);
			if (mean > MEAN_CAP) mean = MEAN_CAP;
			ratio = (mean <<< 16) / ((power_goal == 0) ? 64'sd1 : longint'(power_goal));
			f30 = ONE_Q30 - longint'(damp_q14) * (ratio - 64'sd65536);
			if (f30 >= (longint'(prcd_pkg::FACTOR_HI) <<< 14)) factor = prcd_pkg::FACTOR_HI;
			else if (f30 <= (longint'(prcd_pkg::FACTOR_LO) <<< 14))
				factor = prcd_pkg::FACTOR_LO;
			else factor = f30 >>> 14;
			scaled = round_half_away(longint'(level) * factor, 16);
			if (scaled > 64'sd2147483647) scaled = 64'sd2147483647;
			if (scaled < -64'sd2147483648) scaled = -64'sd2147483648;
			level = scaled[31:0];
			mean_power = mean[23:0];
			mark_time = b.time_stamp;
			acc_power = 0;
			acc_count = 0;
			r.period_done = 1'b1;
		end
		phase = freq_word * b.time_stamp;
		slot = ({32'd0, phase} * 64'(TABLE_DEPTH)) >> 32;
		scaled = round_half_away(longint'(level) * cosine_q15(int'(slot)), 15);
		r.drive_value = scaled[31:0];
		r.amplitude_now = level;
		r.average_power = mean_power;
		return r;
	endfunction

	function automatic logic [23:0] pick_power();
		longint spread, pv;
		int roll;
		roll = $urandom_range(99);
		if (roll < 60) begin
			// mostly near the target so the factor lands inside the clamps
			spread = longint'(power_goal) / 8 + 1;
			pv = longint'(power_goal) + longint'($urandom_range(0, 2 * spread)) - spread;
			if (pv < 0) pv = 0;
			if (pv > MEAN_CAP) pv = MEAN_CAP;
			return pv[23:0];
		end
		if (roll < 80) return 24'($urandom);
		if (roll < 90) return 24'd0;
		return 24'hFF_FFFF;
	endfunction

	task automatic flag(input string msg);
		mismatches++;
		$error("%s", msg);
	endtask

	always @(posedge clk) begin
		prcd_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drive.size() == 0) begin
				flag("result beat with no expected result");
			end else begin
				want = pending_drive.pop_front();
				if (out_data.drive_value !== want.drive_value)
					flag($sformatf("drive_value: expected %0d, got %0d",
						want.drive_value, out_data.drive_value));
				if (out_data.amplitude_now !== want.amplitude_now)
					flag($sformatf("amplitude_now: expected %0d, got %0d",
						want.amplitude_now, out_data.amplitude_now));
				if (out_data.average_power !== want.average_power)
					flag($sformatf("average_power: expected %0d, got %0d",
						want.average_power, out_data.average_power));
				if (out_data.period_done !== want.period_done)
					flag($sformatf("period_done: expected %0d, got %0d",
						want.period_done, out_data.period_done));
			end
		end
	end

	task automatic send_step(input logic [31:0] ts, input logic [23:0] pw);
		prcd_pkg::in_beat_t beat;
		beat.time_stamp = ts;
		beat.power_sample = pw;
		@(negedge clk);
		cfg_valid <= 1'b0;
		while (!steady && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		pending_drive.push_back(predict_drive(beat));
		in_data <= beat;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [prcd_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			prcd_pkg::REG_PHASE_STEP: freq_word = val;
			prcd_pkg::REG_PERIOD_LENGTH: window_len = val;
			prcd_pkg::REG_TARGET_POWER: power_goal = val[23:0];
			prcd_pkg::REG_DAMPING_GAIN: damp_q14 = val[15:0];
			prcd_pkg::REG_INITIAL_AMPLITUDE: level = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [31:0] freq, input logic [31:0] window,
			input logic [31:0] goal, input logic [31:0] damp, input logic [31:0] amp);
		write_reg(prcd_pkg::REG_PHASE_STEP, freq);
		write_reg(prcd_pkg::REG_PERIOD_LENGTH, window);
		write_reg(prcd_pkg::REG_TARGET_POWER, goal);
		write_reg(prcd_pkg::REG_DAMPING_GAIN, damp);
		write_reg(prcd_pkg::REG_INITIAL_AMPLITUDE, amp);
	endtask

	// wait until every expected beat is out, with both inputs idle
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_drive.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic test_reset_defaults();
		send_step(32'd0, 24'd0);
		send_step(32'd0, 24'hFF_FFFF);
		send_step(32'd5, 24'd1);
	endtask

	task automatic test_register_writes();
		settle();
		load_settings(32'h0123_4567, 32'd3, 32'hAB00_03E8, 32'hFFFF_4000, 32'h0001_0000);
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0000_0000);
		send_step(32'd10, 24'd1000);
		send_step(32'd11, 24'd1000);
		send_step(32'd20, 24'd1100);
		send_step(32'd30, 24'd900);
		send_step(32'd40, 24'd0);
	endtask

	task automatic test_cosine_quadrants();
		settle();
		load_settings(32'h4000_0000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'h7FFF_FFFF);
		for (int q = 0; q < 4; q++) send_step(32'(q), 24'd7);
		settle();
		write_reg(prcd_pkg::REG_PHASE_STEP, 32'h0040_0000);
		send_step(32'd1, 24'd7);
		settle();
		write_reg(prcd_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
		send_step(32'hFFFF_FFFF, 24'd7);
		send_step(32'h8000_0001, 24'd7);
	endtask

	task automatic test_factor_clamps();
		settle();
		// no power at full gain: factor pinned high, amplitude saturates
		load_settings(32'h0001_0000, 32'd0, 32'h00FF_FFFF, 32'h0000_FFFF, 32'h7FFF_FFFF);
		send_step(mark_time + 32'd1, 24'd0);
		settle();
		write_reg(prcd_pkg::REG_INITIAL_AMPLITUDE, 32'h8000_0000);
		send_step(mark_time + 32'd1, 24'd0);
		settle();
		// zero target counts as one; full power pins the factor low
		write_reg(prcd_pkg::REG_TARGET_POWER, 32'd0);
		write_reg(prcd_pkg::REG_INITIAL_AMPLITUDE, 32'h0123_4567);
		send_step(mark_time + 32'd1, 24'hFF_FFFF);
		settle();
		write_reg(prcd_pkg::REG_INITIAL_AMPLITUDE, 32'd0);
		send_step(mark_time + 32'd1, 24'd1234);
		send_step(mark_time + 32'd2, 24'd0);
	endtask

	task automatic test_time_wrap();
		settle();
		load_settings(32'h0001_0000, 32'd1000, 32'd500, 32'h0000_2000, 32'h0002_0000);
		send_step(32'hFFFF_FF00, 24'd500);
		send_step(32'h0000_0010, 24'd600);
		send_step(32'h0000_0500, 24'd400);
		send_step(32'h0000_0100, 24'd500);
	endtask

	task automatic test_long_window();
		settle();
		steady = 1'b1;
		load_settings(32'h0000_1000, 32'hFFFF_FFFF, 32'h0080_0000, 32'h0000_4000,
			32'h0010_0000);
		for (int i = 0; i < 72; i++) send_step($urandom, 24'hFF_FFFF);
		settle();
		write_reg(prcd_pkg::REG_PERIOD_LENGTH, 32'd0);
		send_step(mark_time + 32'd1, 24'hFF_FFFF);
		steady = 1'b0;
	endtask

	task automatic test_random_regulation();
		logic [31:0] ts;
		for (int ph = 0; ph < 12; ph++) begin
			settle();
			steady = (ph == 5);
			if (ph == 0)
				load_settings(32'hFFFF_FFFF, 32'd0, 32'h00FF_FFFF, 32'h0000_FFFF,
					32'h7FFF_FFFF);
			else if (ph == 1)
				load_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000);
			else
				load_settings($urandom,
					(ph % 3 == 0) ? $urandom_range(0, 20) : $urandom_range(20, 400),
					$urandom, $urandom, $urandom);
			ts = $urandom;
			repeat (150) begin
				if ($urandom_range(99) < 5) ts = $urandom;
				else ts = ts + $urandom_range(0, 40);
				send_step(ts, pick_power());
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_register_writes();
		test_cosine_quadrants();
		test_factor_clamps();
		test_time_wrap();
		test_long_window();
		test_random_regulation();
		settle();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
